// ===== rtl/bavd_pkg.sv =====
// Shared types and constants for the box-average image downscaler.
// No dependencies.
package bavd_pkg;

  localparam int unsigned MaxWidth = 2048;
  localparam int unsigned ColW     = $clog2(MaxWidth);
  localparam int unsigned ColCntW  = ColW + 1;
  localparam int unsigned WidthW   = 12;
  localparam int unsigned HeightW  = 16;
  localparam int unsigned ScaleW   = 4;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned NumLanes = 4;
  localparam int unsigned AreaW    = 8;
  localparam int unsigned AreaN    = 1 << AreaW;
  localparam int unsigned RecipSh  = 16;
  localparam int unsigned RecipW   = RecipSh + 1;
  localparam int unsigned ProdW    = ChanW + RecipW;
  localparam int unsigned SumW     = ChanW * NumLanes;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ModeW-1:0] ModeOne   = 2'd0;
  localparam logic [ModeW-1:0] ModeThree = 2'd1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWidth  = 2'd0,
    CfgHeight = 2'd1,
    CfgScale  = 2'd2,
    CfgMode   = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    StIdle = 2'd0,
    StDiv  = 2'd1,
    StAcc  = 2'd2
  } state_e;

endpackage

// ===== rtl/bavd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bavd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bavd_lane.sv =====
// One channel lane: byte over block area by reciprocal multiply, then
// accumulate into the partial block sum. Depends on bavd_pkg.
module bavd_lane
  import bavd_pkg::*;
(
  input  logic              clk_i,
  input  logic              div_en_i,
  input  logic [ChanW-1:0]  byte_i,
  input  logic [RecipW-1:0] recip_i,
  input  logic [ChanW-1:0]  psum_i,
  output logic [ChanW-1:0]  part_o
);

  logic [ProdW-1:0] prod;
  logic [ChanW-1:0] quot_q;

  assign prod = ProdW'(byte_i) * ProdW'(recip_i);

  always_ff @(posedge clk_i) begin
    if (div_en_i) begin
      quot_q <= prod[RecipSh +: ChanW];
    end
  end

  assign part_o = psum_i + quot_q;

endmodule

// ===== rtl/box_average_image_downscaler.sv =====
// Box-average image downscaler: each pixel passes accept, divide and accumulate
// before the next is taken; the block result is registered when its last pixel
// accumulates. A held result stalls the accumulate step until it is taken.
// Reset clears position counters and handshake state and sets config defaults;
// data registers and the accumulator RAM are not cleared (a block's first pixel ignores it).
module box_average_image_downscaler
  import bavd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ChanW-1:0]    chan0_i,
  input  logic [ChanW-1:0]    chan1_i,
  input  logic [ChanW-1:0]    chan2_i,
  input  logic [ChanW-1:0]    chan3_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ChanW-1:0]    out_chan0_o,
  output logic [ChanW-1:0]    out_chan1_o,
  output logic [ChanW-1:0]    out_chan2_o,
  output logic [ChanW-1:0]    out_chan3_o,
  output logic                row_end_o,
  output logic                image_end_o
);

  state_e state_q, state_d;

  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic [ScaleW-1:0]  scale_q;
  logic [ModeW-1:0]   mode_q;

  logic [ColW-1:0]    col_q, col_d;
  logic [HeightW-1:0] row_q, row_d;
  logic [ScaleW-1:0]  offx_q, offx_d;
  logic [ScaleW-1:0]  offy_q, offy_d;
  logic [ColW-1:0]    bcol_q, bcol_d;
  logic [ColW-1:0]    x0_q, x0_d;

  logic [ChanW-1:0]   byte_q [NumLanes];
  logic [ScaleW-1:0]  bw_q, bh_q;
  logic [AreaW-1:0]   area_q;

  logic [ColCntW-1:0] w_eff, rem_w;
  logic [HeightW-1:0] h_eff, rem_h;
  logic [ScaleW-1:0]  s_eff, bw, bh;
  logic               in_fire, cfg_fire, div_en, acc_go, emit, out_free;
  logic               last_col, last_row, first_px;
  logic [SumW-1:0]    rdata, psum, res;
  logic [ChanW-1:0]   part [NumLanes];
  logic [NumLanes-1:0] lane_on;
  logic [RecipW-1:0]  recip_lut [AreaN];

  logic               out_valid_q;
  logic [ChanW-1:0]   out_chan_q [NumLanes];
  logic               row_end_q, image_end_q;

  always_comb begin
    if (width_q == '0) begin
      w_eff = ColCntW'(1);
    end else if (32'(width_q) > MaxWidth) begin
      w_eff = ColCntW'(MaxWidth);
    end else begin
      w_eff = ColCntW'(width_q);
    end
    h_eff = (height_q == '0) ? HeightW'(1) : height_q;
    s_eff = (scale_q == '0) ? ScaleW'(1) : scale_q;
    rem_w = w_eff - ColCntW'(x0_q);
    bw    = (rem_w < ColCntW'(s_eff)) ? rem_w[ScaleW-1:0] : s_eff;
    rem_h = h_eff - (row_q - HeightW'(offy_q));
    bh    = (rem_h < HeightW'(s_eff)) ? rem_h[ScaleW-1:0] : s_eff;
  end

  assign last_col = (ColCntW'(col_q) + ColCntW'(1)) == w_eff;
  assign last_row = (row_q + HeightW'(1)) == h_eff;
  assign first_px = (offx_q == '0) && (offy_q == '0);
  assign emit     = ((offx_q + ScaleW'(1)) == bw_q) && ((offy_q + ScaleW'(1)) == bh_q);
  assign out_free = !out_valid_q || !out_stall_i;

  // state machine
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_valid_i) state_d = StDiv;
      StDiv:  state_d = StAcc;
      StAcc:  if (!emit || out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_stall_o  = 1'b1;
    cfg_ready_o = 1'b0;
    div_en      = 1'b0;
    acc_go      = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_stall_o  = 1'b0;
        cfg_ready_o = 1'b1;
      end
      StDiv:  div_en = 1'b1;
      StAcc:  acc_go = !emit || out_free;
      default: ;
    endcase
  end

  assign in_fire  = in_valid_i && !in_stall_o;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    offx_d = offx_q;
    offy_d = offy_q;
    bcol_d = bcol_q;
    x0_d   = x0_q;
    if (cfg_fire) begin
      col_d  = '0;
      row_d  = '0;
      offx_d = '0;
      offy_d = '0;
      bcol_d = '0;
      x0_d   = '0;
    end else if (acc_go) begin
      if (last_col) begin
        col_d  = '0;
        offx_d = '0;
        bcol_d = '0;
        x0_d   = '0;
        if (last_row) begin
          row_d  = '0;
          offy_d = '0;
        end else begin
          row_d  = row_q + HeightW'(1);
          offy_d = ((offy_q + ScaleW'(1)) == s_eff) ? '0 : offy_q + ScaleW'(1);
        end
      end else begin
        col_d = col_q + ColW'(1);
        if ((offx_q + ScaleW'(1)) == s_eff) begin
          offx_d = '0;
          bcol_d = bcol_q + ColW'(1);
          x0_d   = x0_q + ColW'(s_eff);
        end else begin
          offx_d = offx_q + ScaleW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      width_q     <= WidthW'(1);
      height_q    <= HeightW'(1);
      scale_q     <= ScaleW'(1);
      mode_q      <= ModeOne;
      col_q       <= '0;
      row_q       <= '0;
      offx_q      <= '0;
      offy_q      <= '0;
      bcol_q      <= '0;
      x0_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      offx_q  <= offx_d;
      offy_q  <= offy_d;
      bcol_q  <= bcol_d;
      x0_q    <= x0_d;
      if (cfg_fire) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CfgWidth:  width_q  <= cfg_data_i[WidthW-1:0];
          CfgHeight: height_q <= cfg_data_i[HeightW-1:0];
          CfgScale:  scale_q  <= cfg_data_i[ScaleW-1:0];
          CfgMode:   mode_q   <= cfg_data_i[ModeW-1:0];
          default: ;
        endcase
      end
      if (acc_go && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q[0] <= chan0_i;
      byte_q[1] <= chan1_i;
      byte_q[2] <= chan2_i;
      byte_q[3] <= chan3_i;
      bw_q      <= bw;
      bh_q      <= bh;
      area_q    <= AreaW'(bw) * AreaW'(bh);
    end
    if (acc_go && emit) begin
      for (int i = 0; i < NumLanes; i++) begin
        out_chan_q[i] <= res[i*ChanW +: ChanW];
      end
      row_end_q   <= last_col;
      image_end_q <= last_col && last_row;
    end
  end

  for (genvar g = 0; g < AreaN; g++) begin : g_recip
    localparam int unsigned Den = (g == 0) ? 1 : g;
    localparam logic [RecipW-1:0] Rcp = RecipW'(((1 << RecipSh) + Den - 1) / Den);
    assign recip_lut[g] = Rcp;
  end

  bavd_ram #(
    .Width(SumW),
    .Depth(MaxWidth)
  ) u_colsum (
    .clk_i  (clk_i),
    .we_i   (acc_go),
    .waddr_i(bcol_q),
    .wdata_i(res),
    .re_i   (in_fire),
    .raddr_i(bcol_q),
    .rdata_o(rdata)
  );

  assign psum = first_px ? '0 : rdata;

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    bavd_lane u_lane (
      .clk_i   (clk_i),
      .div_en_i(div_en),
      .byte_i  (byte_q[l]),
      .recip_i (recip_lut[area_q]),
      .psum_i  (psum[l*ChanW +: ChanW]),
      .part_o  (part[l])
    );
  end

  // merge lanes, dropping byte positions the mode does not use
  assign lane_on[0] = 1'b1;
  assign lane_on[1] = (mode_q != ModeOne);
  assign lane_on[2] = (mode_q != ModeOne);
  assign lane_on[3] = (mode_q != ModeOne) && (mode_q != ModeThree);

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      res[i*ChanW +: ChanW] = lane_on[i] ? part[i] : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_chan0_o = out_chan_q[0];
  assign out_chan1_o = out_chan_q[1];
  assign out_chan2_o = out_chan_q[2];
  assign out_chan3_o = out_chan_q[3];
  assign row_end_o   = row_end_q;
  assign image_end_o = image_end_q;

`ifndef SYNTH
  a_accept_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == StDiv)
    else $error("accepted word did not start divide");
  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_fire |=> (col_q == '0) && (row_q == '0) && (bcol_q == '0))
    else $error("config write did not restart position");
  a_offs_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (offx_q < s_eff) && (offy_q < s_eff))
    else $error("block offset out of range");
  a_image_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && image_end_o |-> row_end_o)
    else $error("image end without row end");
`endif

endmodule
